### hw/rtl/sld_pkg.sv
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; every other file of the block imports this package.
package sld_pkg;

  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [15:0] MAX_PAYLOAD = 16'd248;
  localparam logic [15:0] IDLE_RESET  = 16'd500;

  // Width of a payload byte counter; it never passes MAX_PAYLOAD.
  localparam int CNT_W = $clog2(int'(MAX_PAYLOAD) + 1);

  // Input op codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // End of packet status codes.
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_CHK = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_IDLE   = 1'b1;

  typedef enum logic [8:0] {
    PS_SYNC1   = 9'b000000001,
    PS_SYNC2   = 9'b000000010,
    PS_LEN1    = 9'b000000100,
    PS_LEN2    = 9'b000001000,
    PS_LENCHK  = 9'b000010000,
    PS_INST    = 9'b000100000,
    PS_IDENT   = 9'b001000000,
    PS_PAYLOAD = 9'b010000000,
    PS_CHK     = 9'b100000000
  } parse_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  inst;
    logic [7:0]  ident;
    logic [15:0] length;
    logic        last;
  } result_t;

endpackage

### hw/rtl/sld_in_reg.sv
// Input register stage of the deframer: holds one accepted transfer.
// Depends on sld_pkg.
module sld_in_reg
  import sld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data,
  input  logic       advance,
  output logic       item_valid,
  output logic       item_op,
  output logic [7:0] item_data
);

  logic       valid_r, valid_nxt;
  logic       op_r;
  logic [7:0] data_r;

  // The stage can take a new transfer when empty or when its item moves on.
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r   <= in_op;
      data_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item_op    = op_r;
  assign item_data  = data_r;

endmodule

### hw/rtl/sld_parser.sv
// Frame parser of the deframer: configuration, parse state and result logic.
// Depends on sld_pkg.
module sld_parser
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_op,
  input  logic [7:0]  item_data,
  input  logic        out_busy,
  output logic        advance,
  output logic        res_valid,
  output result_t     res
);

  logic         enable_r;
  logic [15:0]  idle_timeout_r;

  parse_state_t state_r, state_nxt, cur_state;
  logic [7:0]   length_low_r, length_low_nxt;
  logic [15:0]  packet_length_r, packet_length_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]   running_sum_r, running_sum_nxt;
  logic [7:0]   inst_byte_r, inst_byte_nxt;
  logic [7:0]   id_byte_r, id_byte_nxt;
  logic [15:0]  idle_ticks_r, idle_ticks_nxt;
  logic [7:0]   len_sum;
  logic         is_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      idle_timeout_r <= IDLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable_r       <= cfg_data[0];
        REG_IDLE:   idle_timeout_r <= cfg_data;
        default:    enable_r       <= enable_r;
      endcase
    end
  end

  assign is_byte   = item_valid && (item_op == OP_BYTE) && enable_r;
  // A byte after a long silence is parsed as if waiting for the first sync.
  assign cur_state = (idle_ticks_r >= idle_timeout_r) ? PS_SYNC1 : state_r;
  assign len_sum   = length_low_r + packet_length_r[15:8];
  assign count_inc = byte_count_r + 1'b1;

  always_comb begin
    state_nxt         = state_r;
    length_low_nxt    = length_low_r;
    packet_length_nxt = packet_length_r;
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    inst_byte_nxt     = inst_byte_r;
    id_byte_nxt       = id_byte_r;
    idle_ticks_nxt    = idle_ticks_r;
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.status        = ST_GOOD;
    res.last          = 1'b0;

    if (item_valid && item_op == OP_TICK) begin
      if (idle_ticks_r != 16'hFFFF) begin
        idle_ticks_nxt = idle_ticks_r + 16'd1;
      end
    end else if (is_byte) begin
      idle_ticks_nxt = 16'd0;
      case (cur_state)
        PS_SYNC1: begin
          state_nxt = (item_data == SYNC_BYTE) ? PS_SYNC2 : PS_SYNC1;
        end
        PS_SYNC2: begin
          state_nxt = (item_data == SYNC_BYTE) ? PS_LEN1 : PS_SYNC1;
        end
        PS_LEN1: begin
          length_low_nxt = item_data;
          state_nxt      = PS_LEN2;
        end
        PS_LEN2: begin
          packet_length_nxt = {item_data, length_low_r};
          state_nxt         = PS_LENCHK;
        end
        PS_LENCHK: begin
          state_nxt = (item_data == ~len_sum) ? PS_INST : PS_SYNC1;
        end
        PS_INST: begin
          inst_byte_nxt = item_data;
          state_nxt     = PS_IDENT;
        end
        PS_IDENT: begin
          id_byte_nxt     = item_data;
          byte_count_nxt  = '0;
          running_sum_nxt = 8'd0;
          if (packet_length_r > MAX_PAYLOAD) begin
            state_nxt  = PS_SYNC1;
            res_valid  = 1'b1;
            res.kind   = KIND_REPORT;
            res.status = ST_TOO_LONG;
            res.last   = 1'b1;
          end else begin
            state_nxt = (packet_length_r != 16'd0) ? PS_PAYLOAD : PS_CHK;
          end
        end
        PS_PAYLOAD: begin
          running_sum_nxt  = running_sum_r + item_data;
          byte_count_nxt   = count_inc;
          if (16'(count_inc) >= packet_length_r) begin
            state_nxt = PS_CHK;
          end
          res_valid        = 1'b1;
          res.payload_byte = item_data;
        end
        PS_CHK: begin
          state_nxt      = PS_SYNC1;
          byte_count_nxt = '0;
          res_valid      = 1'b1;
          res.kind       = KIND_REPORT;
          res.status     = (item_data == ~running_sum_r) ? ST_GOOD : ST_BAD_CHK;
          res.last       = 1'b1;
        end
        default: begin
          state_nxt = PS_SYNC1;
        end
      endcase
    end
    // The id byte is reported with the value it carries in this transfer.
    res.inst   = inst_byte_r;
    res.ident  = id_byte_nxt;
    res.length = packet_length_r;
  end

  // An item moves on unless its result would land on a stalled result register.
  assign advance = item_valid && !(res_valid && out_busy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= PS_SYNC1;
      length_low_r    <= 8'd0;
      packet_length_r <= 16'd0;
      byte_count_r    <= '0;
      running_sum_r   <= 8'd0;
      inst_byte_r     <= 8'd0;
      id_byte_r       <= 8'd0;
      idle_ticks_r    <= 16'd0;
    end else if (advance) begin
      state_r         <= state_nxt;
      length_low_r    <= length_low_nxt;
      packet_length_r <= packet_length_nxt;
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      inst_byte_r     <= inst_byte_nxt;
      id_byte_r       <= id_byte_nxt;
      idle_ticks_r    <= idle_ticks_nxt;
    end
  end

endmodule

### hw/rtl/sld_out_reg.sv
// Result register of the deframer: holds one result until it is taken.
// Depends on sld_pkg.
module sld_out_reg
  import sld_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    out_busy,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign valid_nxt = load || (valid_r && out_stall);
  assign out_busy  = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### hw/rtl/sync_length_checksum_deframer_unit.sv
// Top level of the sync/length/checksum packet deframer.
// Depends on sld_pkg, sld_in_reg, sld_parser and sld_out_reg.
//
// The input channel carries received bytes (in_op = 0, value on in_data) and
// one-millisecond ticks (in_op = 1). A transfer takes place at a rising edge
// with in_valid high and in_stall low. Frames are 0xFF 0xFF, a little-endian
// 16-bit length, a length check byte, an instruction byte, an id byte, the
// payload and a checksum byte. Each payload byte leaves on the result channel
// as it arrives (out_kind = 0); the end of a frame gives one report
// (out_kind = 1, out_last = 1) with its status: good, checksum mismatch, or a
// declared length above the maximum payload, reported right after the id.
// A transfer waits in the input register; its result is loaded into the result
// register as the item moves on and is on out_valid from then on. One transfer
// is taken per cycle while in_stall is low. When the receiver stalls, the
// result register holds its result; transfers that give no result still pass,
// and one that gives a result waits in the input register, which then raises
// in_stall. Configuration: index 0 is the enable, index 1 the idle timeout in
// ticks, to be written by the user only while the block is idle (not enforced).
// Reset (synchronous, active low) empties both registers, disables the channel,
// sets the idle timeout to 500 ticks and returns to first sync.
module sync_length_checksum_deframer_unit
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_status,
  output logic [7:0]  out_inst,
  output logic [7:0]  out_ident,
  output logic [15:0] out_length,
  output logic        out_last
);

  logic       item_valid;
  logic       item_op;
  logic [7:0] item_data;
  logic       advance;
  logic       res_valid;
  logic       out_busy;
  result_t    res;
  result_t    out_res;

  // Input register: parts the upstream handshake from the parser.
  sld_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item_op    (item_op),
    .item_data  (item_data)
  );

  // Parser: all per-byte work is done here.
  sld_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_op    (item_op),
    .item_data  (item_data),
    .out_busy   (out_busy),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: loaded only when the parser's item moves on with a result.
  sld_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_busy  (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_status       = out_res.status;
  assign out_inst         = out_res.inst;
  assign out_ident        = out_res.ident;
  assign out_length       = out_res.length;
  assign out_last         = out_res.last;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the sync/length/checksum packet deframer.
// Depends on sld_pkg and sync_length_checksum_deframer_unit. It streams framed
// bytes and ticks into the block and checks each result against its own model.
module tb_top;
  import sld_pkg::*;

  localparam int LIMIT_CYCLES   = 6_000_000;
  localparam int SETTLE         = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int ITEM_TARGET    = 1900;
  // Rough share of the items taken by the directed sections and the long frame.
  localparam int DIRECTED_ITEMS = 800;
  localparam int PHASES         = 6;

  // Frame shapes the stimulus generator builds.
  typedef enum int {
    FR_GOOD, FR_BAD_CHK, FR_BAD_LENCHK, FR_BAD_SYNC, FR_TRUNC, FR_TOO_LONG
  } frame_shape_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_item_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_ENABLE;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        in_op     = OP_BYTE;
  logic [7:0]  in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_status;
  logic [7:0]  out_inst;
  logic [7:0]  out_ident;
  logic [15:0] out_length;
  logic        out_last;

  sync_length_checksum_deframer_unit u_dut (.*);

  initial forever #1 clk = ~clk;

  // Stimulus waiting for the driver, and results the deframer still owes us.
  rx_item_t pending_items[$];
  result_t  expected_results[$];

  int  open_bytes  = 0;    // bytes pushed while the channel is open
  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  in_taken    = 1'b0; // transfer seen on the input at the last rising edge
  bit  quiet       = 1'b0; // no gaps on either side while set
  int  send_gap    = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  int  holds_asked = 0;
  int  holds_done  = 0;

  // Model copy of the registers and the parser state.
  logic         mdl_enable;
  logic [15:0]  mdl_timeout;
  parse_state_t fsm;
  logic [7:0]   len_lo, cur_inst, cur_ident, pay_sum;
  logic [15:0]  frame_len, pay_cnt, quiet_ticks;

  // Advances the model by one accepted item; returns 1 when it gives a result.
  function automatic bit deframe_predict(input logic op, input logic [7:0] b,
                                         output result_t r);
    bit         hit;
    logic [7:0] want;
    hit = 1'b0;
    r   = '0;
    if (op == OP_TICK) begin
      if (quiet_ticks != 16'hFFFF) quiet_ticks++;
      return 1'b0;
    end
    if (!mdl_enable) return 1'b0;
    // A long silence throws away any partial frame before this byte is used.
    if (quiet_ticks >= mdl_timeout) fsm = PS_SYNC1;
    quiet_ticks = '0;
    case (fsm)
      PS_SYNC1: fsm = (b == SYNC_BYTE) ? PS_SYNC2 : PS_SYNC1;
      PS_SYNC2: fsm = (b == SYNC_BYTE) ? PS_LEN1 : PS_SYNC1;
      PS_LEN1: begin
        len_lo = b;
        fsm    = PS_LEN2;
      end
      PS_LEN2: begin
        frame_len = {b, len_lo};
        fsm       = PS_LENCHK;
      end
      PS_LENCHK: begin
        want = 8'hFF - (len_lo + frame_len[15:8]);
        fsm  = (b == want) ? PS_INST : PS_SYNC1;
      end
      PS_INST: begin
        cur_inst = b;
        fsm      = PS_IDENT;
      end
      PS_IDENT: begin
        cur_ident = b;
        pay_cnt   = '0;
        pay_sum   = '0;
        if (frame_len > MAX_PAYLOAD) begin
          fsm      = PS_SYNC1;
          hit      = 1'b1;
          r.kind   = KIND_REPORT;
          r.status = ST_TOO_LONG;
          r.last   = 1'b1;
        end else begin
          fsm = (frame_len != 0) ? PS_PAYLOAD : PS_CHK;
        end
      end
      PS_PAYLOAD: begin
        pay_sum = pay_sum + b;
        pay_cnt = pay_cnt + 1;
        if (pay_cnt >= frame_len) fsm = PS_CHK;
        hit            = 1'b1;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
      end
      PS_CHK: begin
        want     = 8'hFF - pay_sum;
        fsm      = PS_SYNC1;
        pay_cnt  = '0;
        hit      = 1'b1;
        r.kind   = KIND_REPORT;
        r.status = (b == want) ? ST_GOOD : ST_BAD_CHK;
        r.last   = 1'b1;
      end
      default: fsm = PS_SYNC1;
    endcase
    r.inst   = cur_inst;
    r.ident  = cur_ident;
    r.length = frame_len;
    return hit;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d byte=%02h status=%0d inst=%02h id=%02h len=%0d last=%0d",
                     r.kind, r.payload_byte, r.status, r.inst, r.ident, r.length, r.last);
  endfunction

  // Mostly short gaps, a few long ones; none while quiet is set.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    pending_items.push_back('{op: OP_BYTE, data: b});
    if (mdl_enable) open_bytes++;
  endfunction

  function automatic void push_ticks(input int n);
    repeat (n) pending_items.push_back('{op: OP_TICK, data: 8'($urandom)});
  endfunction

  function automatic int frame_len_for(input frame_shape_t shape);
    int r;
    r = $urandom_range(0, 99);
    if (shape == FR_TOO_LONG) begin
      if (r < 20) return int'(MAX_PAYLOAD) + 1;
      if (r < 40) return 65535;
      return $urandom_range(int'(MAX_PAYLOAD) + 1, 65535);
    end
    if (r < 8) return 0;
    if (r < 70) return $urandom_range(1, 12);
    if (r < 93) return $urandom_range(13, 64);
    if (r < 98) return $urandom_range(65, int'(MAX_PAYLOAD) - 1);
    return int'(MAX_PAYLOAD);
  endfunction

  // Builds one frame of the given shape and queues it, with the odd tick
  // slipped in between bytes.
  task automatic push_frame(input int len, input frame_shape_t shape);
    logic [7:0] frame_bytes[$];
    logic [7:0] lo, hi, lchk, sum, b;
    int         keep, strays;
    lo   = len[7:0];
    hi   = len[15:8];
    lchk = 8'hFF - (lo + hi);
    sum  = '0;
    if (shape == FR_BAD_LENCHK) lchk = lchk ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(SYNC_BYTE);
    frame_bytes.push_back((shape == FR_BAD_SYNC) ? 8'($urandom_range(0, 254)) : SYNC_BYTE);
    frame_bytes.push_back(lo);
    frame_bytes.push_back(hi);
    frame_bytes.push_back(lchk);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    if (shape == FR_TOO_LONG) begin
      // The rest of an oversized frame only ever arrives as stray bytes.
      strays = $urandom_range(0, 6);
      repeat (strays) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat (len) begin
        b   = 8'($urandom);
        sum = sum + b;
        frame_bytes.push_back(b);
      end
      b = 8'hFF - sum;
      if (shape == FR_BAD_CHK) b = b ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(b);
    end
    keep = (shape == FR_TRUNC) ? $urandom_range(3, frame_bytes.size() - 1)
                               : frame_bytes.size();
    for (int i = 0; i < keep; i++) begin
      if ($urandom_range(0, 49) == 0) push_ticks($urandom_range(1, 2));
      push_byte(frame_bytes[i]);
    end
    // After a cut frame, let the silence timer resync the parser when it is short.
    if (shape == FR_TRUNC) push_ticks((mdl_timeout <= 40) ? int'(mdl_timeout) : 1);
  endtask

  task automatic run_traffic(input int quota);
    int           stop, r;
    frame_shape_t shape;
    stop = open_bytes + quota;
    while (open_bytes < stop) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else if (r < 12) begin
        push_ticks($urandom_range(1, 4));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      shape = FR_GOOD;
        else if (r < 78) shape = FR_BAD_CHK;
        else if (r < 84) shape = FR_BAD_LENCHK;
        else if (r < 89) shape = FR_BAD_SYNC;
        else if (r < 94) shape = FR_TRUNC;
        else             shape = FR_TOO_LONG;
        push_frame(frame_len_for(shape), shape);
      end
    end
  endtask

  // Waits until every item has been sent and every result has come back,
  // then lets the block finish the items that give no result.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ENABLE) mdl_enable = val[0];
    else mdl_timeout = val;
    @(posedge clk);
  endtask

  // Driver: a new item goes out at a falling edge once the previous transfer
  // has happened and the current gap has run out; a stalled item stays put.
  always @(negedge clk) begin
    rx_item_t item;
    if (in_valid && !in_taken) begin
      // Held by the block; payload must not move.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      item = pending_items.pop_front();
      in_valid <= 1'b1;
      in_op    <= item.op;
      in_data  <= item.data;
      send_gap <= random_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering items
  // and the block has to back up into its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= ($urandom_range(0, 3) == 0) ? random_gap() : 0;
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    result_t predicted, got, oldest;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && !in_stall;
      if (in_taken) begin
        if (deframe_predict(in_op, in_data, predicted)) expected_results.push_back(predicted);
      end
      if (rst_n && out_valid && !out_stall) begin
        got = {out_kind, out_payload_byte, out_status, out_inst, out_ident, out_length,
               out_last};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %s", show(got));
        end else begin
          oldest = expected_results.pop_front();
          if (got !== oldest) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected %s, actual %s", show(oldest), show(got));
          end
        end
      end
    end
  end

  initial begin
    mdl_enable  = 1'b0;
    mdl_timeout = IDLE_RESET;
    fsm         = PS_SYNC1;
    len_lo      = '0;
    cur_inst    = '0;
    cur_ident   = '0;
    pay_sum     = '0;
    frame_len   = '0;
    pay_cnt     = '0;
    quiet_ticks = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Channel still closed after reset: the frame is dropped, the ticks count.
    push_frame(2, FR_GOOD);
    push_ticks(3);
    wait_idle();
    write_reg(REG_ENABLE, 16'd1);

    // Directed: empty frame, oversized frame, broken sync, then a frame cut
    // off by the reset-value idle timeout.
    push_frame(0, FR_GOOD);
    push_frame(65535, FR_TOO_LONG);
    push_frame(1, FR_BAD_SYNC);
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_ticks(int'(IDLE_RESET));
    push_frame(3, FR_GOOD);
    wait_idle();

    // Timeout of two ticks: two ticks inside a frame force a resync.
    write_reg(REG_IDLE, 16'd2);
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_ticks(2);
    push_frame(1, FR_BAD_CHK);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_reg(REG_IDLE, 16'd1);
        1: write_reg(REG_IDLE, 16'hFFFF);
        2: write_reg(REG_IDLE, 16'd7);
        3: write_reg(REG_IDLE, 16'($urandom_range(3, 60)));
        4: write_reg(REG_IDLE, 16'd200);
        default: write_reg(REG_IDLE, 16'($urandom_range(1, 65535)));
      endcase
      quiet = (p == 4);
      if (p == 2) begin
        // Receiver goes away while a long payload streams in.
        holds_asked++;
        push_frame(200, FR_GOOD);
      end
      run_traffic((ITEM_TARGET - DIRECTED_ITEMS) / PHASES);
      wait_idle();
      if (p == 3) begin
        // Closed channel between phases; its bytes leave the idle count alone.
        write_reg(REG_ENABLE, 16'd0);
        push_frame(5, FR_GOOD);
        push_ticks(70);
        push_frame(2, FR_GOOD);
        wait_idle();
        write_reg(REG_ENABLE, 16'd1);
      end
    end
    quiet = 1'b0;
    wait_idle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
